>>> design/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg: shared types and constants of the superpacket prefix encoder
// Widths of the symbol and result fields, codeword constants, and the
// column job and result item types passed between front, queue and back.
// ----------------------------------------------------------------------------
package spe_pkg;

  localparam int BEAM_ROWS  = 4;
  localparam int ROW_W      = $clog2(BEAM_ROWS);
  localparam int CNT_W      = $clog2(BEAM_ROWS);
  localparam int STEP_W     = $clog2(2 * BEAM_ROWS - 1);

  localparam int SYM_W      = 8;
  localparam int CODE_W     = 12;
  localparam int LEN_W      = 4;
  localparam int KIND_W     = 2;
  localparam int STRIPE_W   = 16;
  localparam int TOTBITS_W  = 40;
  localparam int TOTCNT_W   = 32;
  localparam int LIT_VAL_W  = 10;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam logic [APB_AW-1:0] REG_STRIPE_SUPERPACKETS = '0;
  localparam logic [STRIPE_W-1:0] STRIPE_RESET = 16'd1;

  localparam logic [KIND_W-1:0] KIND_ZERO      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LIT       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY_COL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY_PKT = 2'd3;

  localparam logic [LEN_W-1:0] LEN_ZERO  = 4'd1;
  localparam logic [LEN_W-1:0] LEN_LIT   = 4'd12;
  localparam logic [LEN_W-1:0] LEN_EMPTY = 4'd3;

  localparam logic [CODE_W-1:0] CODE_ZERO      = 12'h001;
  localparam logic [CODE_W-1:0] CODE_EMPTY_COL = 12'h000;
  localparam logic [CODE_W-1:0] CODE_EMPTY_PKT = 12'h004;
  localparam logic [1:0]        LIT_PREFIX     = 2'b10;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    sym_t [BEAM_ROWS-1:0] syms;
    logic [CNT_W-1:0]     n_empty;
    logic                 has_syms;
    logic                 pkt_empty;
    logic                 eop;
    logic                 eos;
  } job_t;

  typedef struct packed {
    logic [CODE_W-1:0]    code_bits;
    logic [LEN_W-1:0]     code_length;
    logic [KIND_W-1:0]    code_kind;
    logic                 end_of_packet;
    logic                 end_of_stripe;
    logic [TOTBITS_W-1:0] total_bits;
    logic [TOTCNT_W-1:0]  empty_columns;
    logic [TOTCNT_W-1:0]  empty_packets;
  } res_t;

  // Literal: prefix "01" then 4*value over 10 bits, LSB first
  function automatic logic [CODE_W-1:0] lit_code(input sym_t v);
    logic [LIT_VAL_W-1:0] val;
    val = LIT_VAL_W'({v, 2'b00});
    return {val, LIT_PREFIX};
  endfunction

endpackage

>>> design/spe_front.sv
// ----------------------------------------------------------------------------
// spe_front: column buffer and classifier
// Collects the symbols of one column, classifies the column at its last
// row, tracks pending empty columns and superpacket position, and hands
// a column job to the job queue.
// ----------------------------------------------------------------------------
module spe_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  spe_pkg::sym_t           symbol,
  input  logic [spe_pkg::STRIPE_W-1:0] stripe,
  input  logic                    q_full,
  output logic                    job_push,
  output spe_pkg::job_t           job
);
  import spe_pkg::*;

  sym_t [BEAM_ROWS-1:0] col_r;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0]     col_pos_r, col_pos_nxt;
  logic [CNT_W-1:0]     pend_r, pend_nxt;
  logic [STRIPE_W-1:0]  pkt_r, pkt_nxt;

  logic                 last_row, acc, col_end, all_zero, last_col, eos;
  sym_t [BEAM_ROWS-1:0] col;
  logic [STRIPE_W:0]    pkt_inc;

  always_comb begin
    last_row = (row_r == ROW_W'(BEAM_ROWS - 1));
    full     = last_row && q_full;
    acc      = push && !full;
    col_end  = acc && last_row;

    col                = col_r;
    col[BEAM_ROWS-1]   = symbol;
    all_zero           = ~|col;
    last_col           = (col_pos_r >= CNT_W'(BEAM_ROWS - 2));
    pkt_inc            = {1'b0, pkt_r} + (STRIPE_W+1)'(1);
    eos                = (pkt_inc >= {1'b0, stripe});

    row_nxt     = row_r;
    col_pos_nxt = col_pos_r;
    pend_nxt    = pend_r;
    pkt_nxt     = pkt_r;

    job.syms      = col;
    job.n_empty   = pend_r;
    job.has_syms  = !all_zero;
    job.pkt_empty = 1'b0;
    job.eop       = last_col;
    job.eos       = last_col && eos;
    job_push      = 1'b0;

    if (acc) begin
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end

    if (col_end) begin
      if (!all_zero) begin
        job_push = 1'b1;
        pend_nxt = '0;
      end else if (!last_col) begin
        // hold the empty column until its coding is known
        pend_nxt = pend_r + CNT_W'(1);
      end else begin
        job_push = 1'b1;
        pend_nxt = '0;
        if (pend_r >= CNT_W'(BEAM_ROWS - 2)) begin
          job.pkt_empty = 1'b1;
          job.n_empty   = '0;
        end else begin
          job.n_empty = pend_r + CNT_W'(1);
        end
      end

      if (last_col) begin
        col_pos_nxt = '0;
        pkt_nxt     = eos ? '0 : pkt_inc[STRIPE_W-1:0];
      end else begin
        col_pos_nxt = col_pos_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      col_r[row_r] <= symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_pos_r <= '0;
      pend_r    <= '0;
      pkt_r     <= '0;
    end else begin
      row_r     <= row_nxt;
      col_pos_r <= col_pos_nxt;
      pend_r    <= pend_nxt;
      pkt_r     <= pkt_nxt;
    end
  end

endmodule

>>> design/spe_job_q.sv
// ----------------------------------------------------------------------------
// spe_job_q: column job queue
// Short queue of column jobs between the classifier and the code sequencer.
// ----------------------------------------------------------------------------
module spe_job_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  spe_pkg::job_t wr_job,
  input  logic          rd_en,
  output logic          q_full,
  output logic          q_empty,
  output spe_pkg::job_t rd_job
);
  import spe_pkg::*;

  localparam int CW = $clog2(JOBQ_DEPTH + 1);

  job_t               mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  always_comb begin
    q_full   = (cnt_r == CW'(JOBQ_DEPTH));
    q_empty  = (cnt_r == '0);
    do_wr    = wr_en && !q_full;
    do_rd    = rd_en && !q_empty;
    rd_job   = mem_r[rptr_r];
    wptr_nxt = do_wr ? wptr_r + JOBQ_AW'(1) : wptr_r;
    rptr_nxt = do_rd ? rptr_r + JOBQ_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> design/spe_back.sv
// ----------------------------------------------------------------------------
// spe_back: codeword sequencer
// Walks one column job a codeword per cycle while the two-entry result queue
// toward the output has room: pending empty-column codes, then any symbol
// codes, or a single empty-superpacket code. Keeps the saturating totals.
// ----------------------------------------------------------------------------
module spe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_empty,
  input  spe_pkg::job_t job_head,
  output logic          job_pop,
  input  logic          pop,
  output logic          empty,
  output spe_pkg::res_t head
);
  import spe_pkg::*;

  localparam int OCW = $clog2(OUTQ_DEPTH + 1);

  job_t                 job_r, job_nxt;
  logic                 busy_r, busy_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt, tot_r, tot_nxt;
  logic [TOTBITS_W-1:0] bits_tot_r, bits_tot_nxt;
  logic [TOTCNT_W-1:0]  col_tot_r, col_tot_nxt, pkt_tot_r, pkt_tot_nxt;

  res_t                 oq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   owp_r, owp_nxt, orp_r, orp_nxt;
  logic [OCW-1:0]       ocnt_r, ocnt_nxt;

  logic                 space, produce, is_last, do_pop;
  logic [STEP_W-1:0]    lane_off, n_steps;
  sym_t                 sym;
  logic [TOTBITS_W:0]   bits_sum;
  res_t                 res;

  always_comb begin
    space    = (ocnt_r != OCW'(OUTQ_DEPTH));
    produce  = busy_r && space;
    is_last  = (step_r == tot_r);
    lane_off = step_r - STEP_W'(job_r.n_empty);
    sym      = job_r.syms[lane_off[ROW_W-1:0]];

    res = '0;
    if (job_r.pkt_empty) begin
      res.code_bits   = CODE_EMPTY_PKT;
      res.code_length = LEN_EMPTY;
      res.code_kind   = KIND_EMPTY_PKT;
    end else if (step_r < STEP_W'(job_r.n_empty)) begin
      res.code_bits   = CODE_EMPTY_COL;
      res.code_length = LEN_EMPTY;
      res.code_kind   = KIND_EMPTY_COL;
    end else if (sym == '0) begin
      res.code_bits   = CODE_ZERO;
      res.code_length = LEN_ZERO;
      res.code_kind   = KIND_ZERO;
    end else begin
      res.code_bits   = lit_code(sym);
      res.code_length = LEN_LIT;
      res.code_kind   = KIND_LIT;
    end
    res.end_of_packet = is_last && job_r.eop;
    res.end_of_stripe = is_last && job_r.eos;

    bits_sum     = {1'b0, bits_tot_r} + (TOTBITS_W+1)'(res.code_length);
    bits_tot_nxt = bits_sum[TOTBITS_W] ? '1 : bits_sum[TOTBITS_W-1:0];
    col_tot_nxt  = col_tot_r;
    pkt_tot_nxt  = pkt_tot_r;
    if (res.code_kind == KIND_EMPTY_COL && col_tot_r != '1) begin
      col_tot_nxt = col_tot_r + TOTCNT_W'(1);
    end
    if (res.code_kind == KIND_EMPTY_PKT && pkt_tot_r != '1) begin
      pkt_tot_nxt = pkt_tot_r + TOTCNT_W'(1);
    end
    res.total_bits    = bits_tot_nxt;
    res.empty_columns = col_tot_nxt;
    res.empty_packets = pkt_tot_nxt;

    // load the next job when idle or on the last codeword of this one
    job_pop  = !job_empty && (!busy_r || (produce && is_last));
    n_steps  = job_head.pkt_empty ? STEP_W'(1)
             : STEP_W'(job_head.n_empty) + (job_head.has_syms ? STEP_W'(BEAM_ROWS) : '0);

    job_nxt  = job_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    tot_nxt  = tot_r;
    if (job_pop) begin
      job_nxt  = job_head;
      busy_nxt = 1'b1;
      step_nxt = '0;
      tot_nxt  = n_steps - STEP_W'(1);
    end else if (produce && is_last) begin
      busy_nxt = 1'b0;
    end else if (produce) begin
      step_nxt = step_r + STEP_W'(1);
    end

    empty    = (ocnt_r == '0);
    head     = oq_r[orp_r];
    do_pop   = pop && !empty;
    owp_nxt  = produce ? owp_r + OUTQ_AW'(1) : owp_r;
    orp_nxt  = do_pop ? orp_r + OUTQ_AW'(1) : orp_r;
    ocnt_nxt = ocnt_r + OCW'(produce) - OCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (produce) begin
      oq_r[owp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      step_r     <= '0;
      tot_r      <= '0;
      bits_tot_r <= '0;
      col_tot_r  <= '0;
      pkt_tot_r  <= '0;
      owp_r      <= '0;
      orp_r      <= '0;
      ocnt_r     <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      tot_r  <= tot_nxt;
      if (produce) begin
        bits_tot_r <= bits_tot_nxt;
        col_tot_r  <= col_tot_nxt;
        pkt_tot_r  <= pkt_tot_nxt;
      end
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

>>> design/superpacket_prefix_encoder_top.sv
// ----------------------------------------------------------------------------
// superpacket_prefix_encoder_top: superpacket prefix encoder
// Codes beam symbols column by column into prefix codewords with running
// bit, empty-column and empty-superpacket totals and packet/stripe marks.
//
//   channel   handshake              payload
//   input     push / full            in_symbol
//   result    empty / pop            out_code_bits .. out_empty_packets
//   config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One symbol is taken per cycle unless full is high; full rises only on a
// column's last row while both column jobs in the queue are still waiting.
// A column job yields one codeword per cycle while the result queue has room
// (up to 2*BEAM_ROWS-2 of them), set by the single codeword sequencer;
// a queued job follows the last one directly; an idle sequencer loads it first.
// The two-entry result queue lets the sequencer run while pop is low.
// rst_n is synchronous; all counters and totals clear, stripe length to 1.
// ----------------------------------------------------------------------------
module superpacket_prefix_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [spe_pkg::SYM_W-1:0]       in_symbol,
  output logic                            empty,
  input  logic                            pop,
  output logic [spe_pkg::CODE_W-1:0]      out_code_bits,
  output logic [spe_pkg::LEN_W-1:0]       out_code_length,
  output logic [spe_pkg::KIND_W-1:0]      out_code_kind,
  output logic                            out_end_of_packet,
  output logic                            out_end_of_stripe,
  output logic [spe_pkg::TOTBITS_W-1:0]   out_total_bits,
  output logic [spe_pkg::TOTCNT_W-1:0]    out_empty_columns,
  output logic [spe_pkg::TOTCNT_W-1:0]    out_empty_packets,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spe_pkg::APB_AW-1:0]      paddr,
  input  logic [spe_pkg::APB_DW-1:0]      pwdata,
  output logic [spe_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import spe_pkg::*;

  logic [STRIPE_W-1:0] stripe_r, stripe_nxt;
  logic                cfg_wr;
  logic                q_full, q_empty, job_push, job_pop;
  job_t                job_in, job_head;
  res_t                head;

  always_comb begin
    pready     = 1'b1;
    cfg_wr     = psel && penable && pwrite && pready;
    stripe_nxt = stripe_r;
    if (cfg_wr && paddr == REG_STRIPE_SUPERPACKETS) begin
      stripe_nxt = pwdata[STRIPE_W-1:0];
    end
    prdata = '0;
    if (paddr == REG_STRIPE_SUPERPACKETS) begin
      prdata = APB_DW'(stripe_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stripe_r <= STRIPE_RESET;
    end else begin
      stripe_r <= stripe_nxt;
    end
  end

  spe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .symbol   (in_symbol),
    .stripe   (stripe_r),
    .q_full   (q_full),
    .job_push (job_push),
    .job      (job_in)
  );

  spe_job_q u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .rd_en   (job_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rd_job  (job_head)
  );

  spe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign out_code_bits     = head.code_bits;
  assign out_code_length   = head.code_length;
  assign out_code_kind     = head.code_kind;
  assign out_end_of_packet = head.end_of_packet;
  assign out_end_of_stripe = head.end_of_stripe;
  assign out_total_bits    = head.total_bits;
  assign out_empty_columns = head.empty_columns;
  assign out_empty_packets = head.empty_packets;

endmodule

>>> design/spe_chk.sv
// ----------------------------------------------------------------------------
// spe_chk: port checker for the superpacket prefix encoder
// Watches the result port for codeword shape, mark ordering and
// monotonic bit and empty-column totals; bound to the top level.
// ----------------------------------------------------------------------------
module spe_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          empty,
  input logic                          pop,
  input logic [spe_pkg::CODE_W-1:0]    out_code_bits,
  input logic [spe_pkg::LEN_W-1:0]     out_code_length,
  input logic [spe_pkg::KIND_W-1:0]    out_code_kind,
  input logic                          out_end_of_packet,
  input logic                          out_end_of_stripe,
  input logic [spe_pkg::TOTBITS_W-1:0] out_total_bits,
  input logic [spe_pkg::TOTCNT_W-1:0]  out_empty_columns
);
  import spe_pkg::*;

  // length and fixed bits follow from the kind
  a_code_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |->
      (out_code_kind == KIND_ZERO && out_code_length == LEN_ZERO &&
       out_code_bits == CODE_ZERO) ||
      (out_code_kind == KIND_LIT && out_code_length == LEN_LIT &&
       out_code_bits[1:0] == LIT_PREFIX && out_code_bits[CODE_W-1:4] != '0) ||
      (out_code_kind == KIND_EMPTY_COL && out_code_length == LEN_EMPTY &&
       out_code_bits == CODE_EMPTY_COL) ||
      (out_code_kind == KIND_EMPTY_PKT && out_code_length == LEN_EMPTY &&
       out_code_bits == CODE_EMPTY_PKT && out_end_of_packet))
    else $error("codeword fields disagree with kind");

  a_stripe_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_end_of_stripe |-> out_end_of_packet)
    else $error("stripe end without packet end");

  a_bits_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) ##1 !empty |-> out_total_bits > $past(out_total_bits) ||
                                   out_total_bits == '1)
    else $error("bit total did not advance");

  a_cols_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) ##1 !empty |-> out_empty_columns >= $past(out_empty_columns))
    else $error("empty column total went back");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_total_bits))
    else $error("waiting item changed");

endmodule

bind superpacket_prefix_encoder_top spe_chk u_spe_chk (.*);

>>> bench/superpacket_prefix_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// superpacket_prefix_encoder_top_tb: self-checking bench for the prefix encoder
// Streams beam symbols into the encoder and predicts every codeword, its
// running totals and its packet and stripe marks from its own model of the
// column buffer. Each popped codeword is compared field by field.
// ----------------------------------------------------------------------------
module superpacket_prefix_encoder_top_tb;
  import spe_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int COLUMNS       = BEAM_ROWS - 1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [SYM_W-1:0]      in_symbol;
  logic                  empty;
  logic                  pop;
  logic [CODE_W-1:0]     out_code_bits;
  logic [LEN_W-1:0]      out_code_length;
  logic [KIND_W-1:0]     out_code_kind;
  logic                  out_end_of_packet;
  logic                  out_end_of_stripe;
  logic [TOTBITS_W-1:0]  out_total_bits;
  logic [TOTCNT_W-1:0]   out_empty_columns;
  logic [TOTCNT_W-1:0]   out_empty_packets;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  superpacket_prefix_encoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_symbol         (in_symbol),
    .empty             (empty),
    .pop               (pop),
    .out_code_bits     (out_code_bits),
    .out_code_length   (out_code_length),
    .out_code_kind     (out_code_kind),
    .out_end_of_packet (out_end_of_packet),
    .out_end_of_stripe (out_end_of_stripe),
    .out_total_bits    (out_total_bits),
    .out_empty_columns (out_empty_columns),
    .out_empty_packets (out_empty_packets),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk = ~clk;

  // Encoder model state
  sym_t                 column_buf [BEAM_ROWS];
  int                   row_idx      = 0;
  int                   col_idx      = 0;
  int                   empty_run    = 0;
  logic [STRIPE_W-1:0]  packet_idx   = '0;
  logic [STRIPE_W-1:0]  stripe_len   = STRIPE_RESET;
  logic [TOTBITS_W-1:0] bit_count    = '0;
  logic [TOTCNT_W-1:0]  empty_col_count = '0;
  logic [TOTCNT_W-1:0]  empty_pkt_count = '0;

  res_t expected_codewords[$];
  res_t column_codes[$];

  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int rx_hold_request = 0;
  int rx_hold_left   = 0;

  // Append one codeword of the current column, totals included
  function automatic void add_codeword(logic [CODE_W-1:0] bits, logic [LEN_W-1:0] len,
                                       logic [KIND_W-1:0] kind);
    res_t c;
    if (bit_count > {TOTBITS_W{1'b1}} - len) bit_count = '1;
    else bit_count = bit_count + len;
    if (kind == KIND_EMPTY_COL && empty_col_count != '1) empty_col_count++;
    if (kind == KIND_EMPTY_PKT && empty_pkt_count != '1) empty_pkt_count++;
    c.code_bits     = bits;
    c.code_length   = len;
    c.code_kind     = kind;
    c.end_of_packet = 1'b0;
    c.end_of_stripe = 1'b0;
    c.total_bits    = bit_count;
    c.empty_columns = empty_col_count;
    c.empty_packets = empty_pkt_count;
    column_codes.push_back(c);
  endfunction

  task automatic predict_codewords(input sym_t s);
    bit has_data;
    bit last_col;
    int n;
    has_data = 1'b0;
    column_codes.delete();
    if (row_idx >= BEAM_ROWS) row_idx = 0;
    column_buf[row_idx] = s;
    if (row_idx < BEAM_ROWS - 1) begin
      row_idx++;
      return;
    end
    row_idx = 0;
    for (int r = 0; r < BEAM_ROWS; r++)
      if (column_buf[r] != '0) has_data = 1'b1;
    last_col = (col_idx >= BEAM_ROWS - 2);

    if (has_data) begin
      repeat (empty_run) add_codeword(CODE_EMPTY_COL, LEN_EMPTY, KIND_EMPTY_COL);
      empty_run = 0;
      for (int r = 0; r < BEAM_ROWS; r++) begin
        if (column_buf[r] == '0) add_codeword(CODE_ZERO, LEN_ZERO, KIND_ZERO);
        else add_codeword({column_buf[r], 2'b00, LIT_PREFIX}, LEN_LIT, KIND_LIT);
      end
    end else if (!last_col) begin
      // hold the empty column until its coding is known
      empty_run++;
      col_idx++;
      return;
    end else begin
      if (empty_run >= BEAM_ROWS - 2) add_codeword(CODE_EMPTY_PKT, LEN_EMPTY, KIND_EMPTY_PKT);
      else repeat (empty_run + 1) add_codeword(CODE_EMPTY_COL, LEN_EMPTY, KIND_EMPTY_COL);
      empty_run = 0;
    end

    n = column_codes.size();
    if (last_col) begin
      col_idx = 0;
      column_codes[n-1].end_of_packet = 1'b1;
      if (({1'b0, packet_idx} + 17'd1) >= {1'b0, stripe_len}) begin
        column_codes[n-1].end_of_stripe = 1'b1;
        packet_idx = '0;
      end else begin
        packet_idx = packet_idx + 1'b1;
      end
    end else begin
      col_idx++;
    end
    foreach (column_codes[i]) expected_codewords.push_back(column_codes[i]);
  endtask

  function automatic void check_field(string name, logic [TOTBITS_W-1:0] want,
                                      logic [TOTBITS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_codeword();
    res_t want;
    if (expected_codewords.size() == 0) begin
      $error("code_bits: expected none, actual %0h", out_code_bits);
      mismatch_count++;
      return;
    end
    want = expected_codewords.pop_front();
    check_field("code_bits", want.code_bits, out_code_bits);
    check_field("code_length", want.code_length, out_code_length);
    check_field("code_kind", want.code_kind, out_code_kind);
    check_field("end_of_packet", want.end_of_packet, out_end_of_packet);
    check_field("end_of_stripe", want.end_of_stripe, out_end_of_stripe);
    check_field("total_bits", want.total_bits, out_total_bits);
    check_field("empty_columns", want.empty_columns, out_empty_columns);
    check_field("empty_packets", want.empty_packets, out_empty_packets);
  endtask

  // Result side: check each popped item, then pick pop for the next cycle
  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_codeword();
    if (rx_hold_request > 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_symbol(input sym_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    in_symbol <= s;
    do @(posedge clk); while (full);
    predict_codewords(s);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_codewords.size() != 0) @(posedge clk);
    // let a column that makes no codeword finish inside the block
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stripe_len(input logic [STRIPE_W-1:0] len);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STRIPE_SUPERPACKETS;
    pwdata  <= {{(APB_DW-STRIPE_W){1'b0}}, len};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    stripe_len = len;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(APB_DW-STRIPE_W){1'b0}}, len}) begin
      $error("stripe_superpackets: expected %0h, actual %0h", len, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_packet();
    int shape;
    shape = $urandom_range(99);
    for (int c = 0; c < COLUMNS; c++) begin
      bit blank_col;
      blank_col = ($urandom_range(99) < 35);
      for (int r = 0; r < BEAM_ROWS; r++) begin
        int pick;
        pick = $urandom_range(99);
        if (shape < 15) send_symbol('0);
        else if (shape < 25) send_symbol(sym_t'($urandom_range(255)));
        else if (blank_col || pick < 30) send_symbol('0);
        else if (pick < 40) send_symbol(8'hFF);
        else send_symbol(sym_t'($urandom_range(1, 255)));
      end
    end
  endtask

  // Literals at the symbol extremes, pending empty column, trailing empty column
  task automatic test_column_codes();
    tx_idle_pct = 32;
    rx_idle_pct = 85;
    write_stripe_len(16'd2);
    repeat (BEAM_ROWS) send_symbol('0);
    send_symbol(8'h00);
    send_symbol(8'hFF);
    send_symbol(8'h01);
    send_symbol(8'h80);
    repeat (BEAM_ROWS) send_symbol('0);
    wait_drained();
  endtask

  // All-zero superpacket, with the stripe length cut to zero mid-stripe
  task automatic test_empty_superpacket();
    write_stripe_len(16'd0);
    repeat (BEAM_ROWS * COLUMNS) send_symbol('0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [STRIPE_W-1:0] len, input int packets);
    write_stripe_len(len);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (packets) send_random_packet();
    // break column alignment
    repeat ($urandom_range(0, 5)) send_symbol(sym_t'($urandom_range(255)));
  endtask

  // Fill the block against a stalled receiver, then pause the sender
  task automatic test_backpressure();
    write_stripe_len(16'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_request = 200;
    repeat (2) send_random_packet();
    wait_drained();
    repeat (2) send_random_packet();
    wait_drained();
  endtask

  initial begin
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_symbol <= '0;
    pop       <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_column_codes();
    test_empty_superpacket();
    test_random_traffic(32, 85, 16'd3, 11);
    test_random_traffic(85, 32, 16'hFFFF, 11);
    test_random_traffic(0, 0, STRIPE_W'($urandom_range(1, 4)), 6);
    test_backpressure();
    wait_drained();

    if (mismatch_count == 0 && expected_codewords.size() == 0) begin
      $display("[superpacket_prefix_encoder_top] OK");
    end else begin
      $display("[superpacket_prefix_encoder_top] ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[superpacket_prefix_encoder_top] ERROR");
    $finish;
  end

endmodule
